// ===== sv/lpc_pkg.sv =====
package lpc_pkg;

    localparam int AesRounds = 10;
    localparam int CfgAddrWidth = 6;

    localparam logic [2:0] RegKeyHigh = 3'd0;
    localparam logic [2:0] RegKeyLow  = 3'd1;
    localparam logic [2:0] RegDir     = 3'd2;
    localparam logic [2:0] RegDevAddr = 3'd3;
    localparam logic [2:0] RegFcnt    = 3'd4;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic [7:0]  block_number;
    } in_req_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic [7:0]  echo_number;
    } out_req_t;

    // Per-stage payload carried alongside the AES state
    typedef struct packed {
        logic [127:0] state;
        logic [127:0] rkey;
        logic [7:0]   rcon;
        logic [127:0] data;
        logic [7:0]   number;
    } stage_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== sv/lpc_round.sv =====
// One AES round plus the matching key-schedule step, registered.
module lpc_round #(
    parameter bit LastRound = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  lpc_pkg::stage_t      in_stage,
    output logic                 out_valid,
    output lpc_pkg::stage_t      out_stage
);

    logic [127:0] sub_shift;
    logic [127:0] mixed;
    logic [127:0] next_key;
    logic [7:0]   t [16];
    logic [7:0]   m [16];
    logic [31:0]  w;
    logic         valid_reg;
    lpc_pkg::stage_t stage_reg;
    lpc_pkg::stage_t stage_next;

    // byte i sits at bits [127-8i -: 8]
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[i + 4*c] = lpc_pkg::sbox(
                    in_stage.state[127 - 8*(i + 4*((c + i) % 4)) -: 8]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[4*c]   = t[4*c] ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3]
                       ^ lpc_pkg::xtime(t[4*c] ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3]
                       ^ lpc_pkg::xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3]
                       ^ lpc_pkg::xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3]
                       ^ lpc_pkg::xtime(t[4*c+3] ^ t[4*c]);
        end
        for (int i = 0; i < 16; i++)
        begin
            sub_shift[127 - 8*i -: 8] = t[i];
            mixed[127 - 8*i -: 8]     = m[i];
        end
    end

    // RotWord/SubWord/Rcon on the last key word
    always_comb
    begin
        w = {lpc_pkg::sbox(in_stage.rkey[23:16]) ^ in_stage.rcon,
             lpc_pkg::sbox(in_stage.rkey[15:8]),
             lpc_pkg::sbox(in_stage.rkey[7:0]),
             lpc_pkg::sbox(in_stage.rkey[31:24])};
        next_key[127:96] = in_stage.rkey[127:96] ^ w;
        next_key[95:64]  = in_stage.rkey[95:64] ^ next_key[127:96];
        next_key[63:32]  = in_stage.rkey[63:32] ^ next_key[95:64];
        next_key[31:0]   = in_stage.rkey[31:0] ^ next_key[63:32];
    end

    always_comb
    begin
        stage_next        = in_stage;
        stage_next.rkey   = next_key;
        stage_next.rcon   = lpc_pkg::xtime(in_stage.rcon);
        stage_next.state  = (LastRound ? sub_shift : mixed) ^ next_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// ===== sv/lpc_cfg.sv =====
// APB register file holding key and counter-block fields.
module lpc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpc_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic [127:0]                      key,
    output logic [127:0]                      ctr_base
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        dir_reg;
    logic [31:0] dev_addr_reg;
    logic [31:0] fcnt_reg;
    logic [2:0]  idx;
    logic        wr;

    assign idx = paddr[5:3];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            dir_reg      <= 1'b0;
            dev_addr_reg <= '0;
            fcnt_reg     <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                lpc_pkg::RegKeyHigh: key_high_reg <= pwdata;
                lpc_pkg::RegKeyLow:  key_low_reg  <= pwdata;
                lpc_pkg::RegDir:     dir_reg      <= pwdata[0];
                lpc_pkg::RegDevAddr: dev_addr_reg <= pwdata[31:0];
                lpc_pkg::RegFcnt:    fcnt_reg     <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lpc_pkg::RegKeyHigh: prdata = key_high_reg;
            lpc_pkg::RegKeyLow:  prdata = key_low_reg;
            lpc_pkg::RegDir:     prdata = {63'd0, dir_reg};
            lpc_pkg::RegDevAddr: prdata = {32'd0, dev_addr_reg};
            lpc_pkg::RegFcnt:    prdata = {32'd0, fcnt_reg};
            default:             prdata = '0;
        endcase
    end

    assign key = {key_high_reg, key_low_reg};
    // counter block with its final byte (the block number) left zero
    assign ctr_base = {8'h01, 32'd0, 7'd0, dir_reg, dev_addr_reg, fcnt_reg, 16'd0};

endmodule

// ===== sv/lorawan_payload_ctr_cipher_core.sv =====
// Pipeline from request accept to result valid: the stage-0 register loads at the accept edge,
// then one register per round and the XOR/output register.
// Throughput: one request per cycle; the whole pipe advances together
// and holds when the output register is full and not being taken.
// Reset: rst_n asynchronous, clears all valid bits and the config registers; data registers are not reset.
module lorawan_payload_ctr_cipher_core #(
    parameter int AES_ROUNDS = lpc_pkg::AesRounds
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpc_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [63:0]                       pwdata,
    output logic [63:0]                       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lpc_pkg::in_req_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lpc_pkg::out_req_t                 out_data
);

    logic [127:0]    key;
    logic [127:0]    ctr_base;
    logic            adv;
    logic            v   [AES_ROUNDS+1];
    lpc_pkg::stage_t stg [AES_ROUNDS+1];
    logic            s0_valid_reg;
    lpc_pkg::stage_t s0_reg;
    lpc_pkg::stage_t s0_next;
    logic            out_valid_reg;
    lpc_pkg::out_req_t out_reg;

    assign pready = 1'b1;

    lpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .key      (key),
        .ctr_base (ctr_base)
    );

    // Pipe moves as one; stalls only when the output slot is held.
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // Stage 0: build counter block and apply the initial round key
    always_comb
    begin
        s0_next.state  = {ctr_base[127:8], in_data.block_number} ^ key;
        s0_next.rkey   = key;
        s0_next.rcon   = 8'h01;
        s0_next.data   = {in_data.block_high, in_data.block_low};
        s0_next.number = in_data.block_number;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= s0_next;
        end
    end

    assign v[0]   = s0_valid_reg;
    assign stg[0] = s0_reg;

    for (genvar r = 0; r < AES_ROUNDS; r++)
    begin : g_round
        lpc_round #(.LastRound(r == AES_ROUNDS - 1)) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (v[r]),
            .in_stage  (stg[r]),
            .out_valid (v[r+1]),
            .out_stage (stg[r+1])
        );
    end

    // Keystream XOR into output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v[AES_ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            {out_reg.cipher_high, out_reg.cipher_low} <=
                stg[AES_ROUNDS].data ^ stg[AES_ROUNDS].state;
            out_reg.echo_number <= stg[AES_ROUNDS].number;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> v[0])
        else $error("accepted request lost at stage 0");

endmodule

// ===== tb/lorawan_payload_ctr_cipher_checker.sv =====
module lorawan_payload_ctr_cipher_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    input  logic              pready,
    input  logic              in_valid,
    input  logic              in_ready,
    input  lpc_pkg::in_req_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  lpc_pkg::out_req_t out_data,
    output int                fail_count,
    output int                pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [127:0]      session_key;
    logic              dir_bit;
    logic [31:0]       dev_addr;
    logic [31:0]       fcnt;
    lpc_pkg::out_req_t cipher_queue[$];

    localparam logic [7:0] SBOX[256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] dbl(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte k of a 128-bit word sits in bits 127-8k down
    function automatic logic [127:0] aes128(logic [127:0] key, logic [127:0] blk);
        logic [7:0] rk[176];
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] w[4];
        logic [7:0] rc;
        logic [7:0] x, a0, a1, a2, a3, al;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127-8*i -: 8];
            st[i] = blk[127-8*i -: 8] ^ rk[i];
        end
        for (int i = 16; i < 176; i += 4)
        begin
            for (int c = 0; c < 4; c++) w[c] = rk[i-4+c];
            if (i % 16 == 0)
            begin
                x = w[0];
                w[0] = SBOX[w[1]] ^ rc;
                w[1] = SBOX[w[2]];
                w[2] = SBOX[w[3]];
                w[3] = SBOX[x];
                rc = dbl(rc);
            end
            for (int c = 0; c < 4; c++) rk[i+c] = rk[i-16+c] ^ w[c];
        end
        for (int r = 1; r <= 10; r++)
        begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    tmp[i+4*c] = SBOX[st[i+4*((c+i)%4)]];
            if (r != 10)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    tmp[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
                    tmp[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
                    tmp[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
                    tmp[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16*r+i];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    function automatic lpc_pkg::out_req_t encrypt_block(lpc_pkg::in_req_t req);
        logic [127:0] ctr, ks, ct;
        lpc_pkg::out_req_t o;
        ctr = {8'h01, 32'h0, 7'h0, dir_bit, dev_addr, fcnt, 8'h00, req.block_number};
        ks = aes128(session_key, ctr);
        ct = {req.block_high, req.block_low} ^ ks;
        o.cipher_high = ct[127:64];
        o.cipher_low = ct[63:0];
        o.echo_number = req.block_number;
        return o;
    endfunction

    assign pending_count = cipher_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        lpc_pkg::out_req_t want;
        if (!rst_n)
        begin
            session_key = '0;
            dir_bit = 1'b0;
            dev_addr = '0;
            fcnt = '0;
            fail_count = 0;
            cipher_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    lpc_pkg::RegKeyHigh: session_key[127:64] = pwdata;
                    lpc_pkg::RegKeyLow:  session_key[63:0] = pwdata;
                    lpc_pkg::RegDir:     dir_bit = pwdata[0];
                    lpc_pkg::RegDevAddr: dev_addr = pwdata[31:0];
                    lpc_pkg::RegFcnt:    fcnt = pwdata[31:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (cipher_queue.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             out_data);
                    fail_count++;
                end
                else
                begin
                    want = cipher_queue.pop_front();
                    if (want.cipher_high !== out_data.cipher_high)
                    begin
                        $display("%0t: cipher_high expected %h actual %h", $time,
                                 want.cipher_high, out_data.cipher_high);
                        fail_count++;
                    end
                    if (want.cipher_low !== out_data.cipher_low)
                    begin
                        $display("%0t: cipher_low expected %h actual %h", $time,
                                 want.cipher_low, out_data.cipher_low);
                        fail_count++;
                    end
                    if (want.echo_number !== out_data.echo_number)
                    begin
                        $display("%0t: echo_number expected %h actual %h", $time,
                                 want.echo_number, out_data.echo_number);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                cipher_queue.push_back(encrypt_block(in_data));
        end
    end
endmodule

// ===== tb/lorawan_payload_ctr_cipher_core_test.sv =====
module lorawan_payload_ctr_cipher_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [5:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    lpc_pkg::in_req_t  in_data;
    logic              out_valid;
    logic              out_ready;
    lpc_pkg::out_req_t out_data;
    int                fail_count;
    int                pending_count;

    // Receiver behaviour: 0 random idling, 1 always ready, 2 long hold-off
    int          sink_mode;

    lorawan_payload_ctr_cipher_core uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    lorawan_payload_ctr_cipher_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Hard stop well beyond the slowest legitimate run
    initial
    begin
        #5ms;
        $display("** lorawan_payload_ctr_cipher_core: FAILED **");
        $finish;
    end

    // APB write: setup then access phase, all changes on the falling edge
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
    endtask

    task automatic load_session(logic [63:0] kh, logic [63:0] kl, logic d,
                                logic [31:0] addr, logic [31:0] cnt);
        write_reg(lpc_pkg::RegKeyHigh, kh);
        write_reg(lpc_pkg::RegKeyLow, kl);
        write_reg(lpc_pkg::RegDir, {63'h0, d});
        write_reg(lpc_pkg::RegDevAddr, {32'h0, addr});
        write_reg(lpc_pkg::RegFcnt, {32'h0, cnt});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Offer one request, holding it until taken; gaps decides random idling
    task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic [7:0] num, bit gaps);
        if (gaps)
            while ($urandom_range(99) < 37)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        in_data <= '{block_high: hi, block_low: lo, block_number: num};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Pattern with occasional all-zero / all-one halves to hit extremes
    function automatic logic [63:0] payload_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // Wait until the pipe has drained before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (lpc_pkg::AesRounds + 4) @(negedge clk);
    endtask

    // Receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (sink_mode == 1)
            out_ready <= 1'b1;
        else if (sink_mode == 2)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= 37);
    end

    // Long hold-off on the receiver while the sender keeps offering
    initial
    begin
        int held;
        wait (sink_mode == 2);
        held = 0;
        while (held < 60)
        begin
            @(negedge clk);
            held++;
        end
        sink_mode = 0;
    end

    initial
    begin
        logic [7:0] num;
        int frame;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        sink_mode = 1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset registers, extremes of payload and block number
        send_block('0, '0, 8'd1, 1'b0);
        send_block('1, '1, 8'd0, 1'b0);
        send_block('1, '0, 8'd255, 1'b0);
        drain();
        // Standard spec-style session: key all ones, downlink, maximal counters
        load_session('1, '1, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
        send_block('0, '0, 8'd0, 1'b0);
        send_block('1, '1, 8'd255, 1'b0);
        send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 8'd1, 1'b0);
        for (int i = 0; i < 8; i++)
            send_block(64'h1 << (8 * i), 64'h80 << (8 * i), 8'd1 << i, 1'b0);
        drain();
        load_session(64'h2b7e_1516_28ae_d2a6, 64'habf7_1588_09cf_4f3c, 1'b0,
                     32'h2601_1bda, 32'h0000_0001);
        for (int i = 1; i <= 4; i++)
            send_block(64'h4865_6c6c_6f00_0000, 64'h0, i[7:0], 1'b0);
        drain();

        // Random sessions: each sends one frame of mostly consecutively numbered blocks
        sink_mode = 0;
        for (int s = 0; s < 10; s++)
        begin
            load_session(rand64(), rand64(), 1'($urandom_range(1)),
                         $urandom(), $urandom());
            frame = $urandom_range(40, 60);
            num = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'd1;
            if (s == 3)
                sink_mode = 2;
            for (int k = 0; k < frame; k++)
            begin
                send_block(payload_word(), payload_word(),
                           ($urandom_range(9) == 0) ? 8'($urandom()) : num,
                           (s % 4) != 1);
                num++;
            end
            if (s == 6)
                sink_mode = 1;
            drain();
            if (s == 6)
                sink_mode = 0;
        end
        // Set every session setting back to all zeros after non-zero traffic
        load_session('0, '0, 1'b0, '0, '0);
        for (int k = 0; k < 20; k++)
            send_block(payload_word(), payload_word(), 8'($urandom()), 1'b1);

        drain();
        if (fail_count == 0)
            $display("** lorawan_payload_ctr_cipher_core: PASSED **");
        else
            $display("** lorawan_payload_ctr_cipher_core: FAILED **");
        $finish;
    end
endmodule
